@@ hdl/udhcd_pkg.sv @@
// Package for the dual-hash checksum block: constants, types and the bit shuffle.
package udhcd_pkg;

  localparam logic [31:0] Times33Seed = 32'd5381;
  localparam logic [31:0] EmptySum    = 32'h0000_1000;
  localparam logic [31:0] Mul33       = 32'd33;
  localparam logic [31:0] Mul65599    = 32'd65599;
  localparam logic [31:0] Recip10     = 32'hCCCC_CCCD;
  localparam int          RecipShift  = 35;
  localparam int          QuotWidth   = 64 - RecipShift;

  typedef enum logic [1:0] {
    DigIdle,
    DigMul,
    DigAcc,
    DigDone
  } dig_state_e;

  typedef struct packed {
    logic [31:0] checksum;
    logic [3:0]  digit;
  } result_t;

  function automatic logic [31:0] mix_hashes(input logic [31:0] h1, input logic [31:0] h2);
    logic [31:0] x;
    logic [31:0] mid;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] rest;
    x    = ((h1 >> 6) & 32'h03ff_ffc0) | ((h1 >> 2) & 32'h0000_003f);
    x    = ((x >> 4) & 32'h003f_fc00) | (x & 32'h0000_03ff);
    x    = ((x >> 4) & 32'h0003_c000) | (x & 32'h0000_3fff);
    mid  = (((x & 32'h0000_03c0) << 4) | (x & 32'h0000_003c)) << 2;
    lo   = h2 & 32'h0000_0f0f;
    hi   = h2 & 32'h0f0f_0000;
    rest = ((x & 32'hffff_c000) << 4) | (x & 32'h0000_3c00);
    return (rest << 10) | mid | lo | hi;
  endfunction

endpackage

@@ hdl/udhcd_hash.sv @@
// Running times-33 and times-65599 hashes with the final shuffle.
module udhcd_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  char_byte_i,
  input  logic        no_char_i,
  input  logic        last_i,
  output logic [31:0] sum_o
);

  logic [31:0] h1_q, h1_d;
  logic [31:0] h2_q, h2_d;
  logic        seen_q, seen_d;
  logic [31:0] sx;
  logic [31:0] h1_prod;
  logic [31:0] h2_prod;

  assign sx      = {{24{char_byte_i[7]}}, char_byte_i};
  assign h1_prod = h1_q * udhcd_pkg::Mul33;
  assign h2_prod = h2_q * udhcd_pkg::Mul65599;

  always_comb begin
    h1_d   = no_char_i ? h1_q : h1_prod + sx;
    h2_d   = no_char_i ? h2_q : h2_prod + sx;
    seen_d = seen_q | ~no_char_i;
  end

  assign sum_o = seen_d ? udhcd_pkg::mix_hashes(h1_d, h2_d) : udhcd_pkg::EmptySum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q   <= udhcd_pkg::Times33Seed;
      h2_q   <= '0;
      seen_q <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        h1_q   <= udhcd_pkg::Times33Seed;
        h2_q   <= '0;
        seen_q <= 1'b0;
      end else begin
        h1_q   <= h1_d;
        h2_q   <= h2_d;
        seen_q <= seen_d;
      end
    end
  end

endmodule

@@ hdl/udhcd_div10.sv @@
// Shared divide-by-ten unit: reciprocal multiply, registered, then quotient and remainder.
module udhcd_div10 (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [31:0]                      value_i,
  output logic [udhcd_pkg::QuotWidth-1:0]  quot_o,
  output logic [3:0]                       rem_o
);

  logic [63:0] prod_q;
  logic [31:0] val_q;
  logic [32:0] quot_x10;
  logic [32:0] diff;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {32'b0, value_i} * {32'b0, udhcd_pkg::Recip10};
      val_q  <= value_i;
    end
  end

  assign quot_o   = prod_q[63:udhcd_pkg::RecipShift];
  assign quot_x10 = {(33 - udhcd_pkg::QuotWidth - 3)'(0), quot_o, 3'b0}
                  + {(33 - udhcd_pkg::QuotWidth - 1)'(0), quot_o, 1'b0};
  assign diff     = {1'b0, val_q} - quot_x10;
  assign rem_o    = diff[3:0];

endmodule

@@ hdl/udhcd_digit.sv @@
// Sequencer for the check digit, one decimal digit per pass through the divide unit.
module udhcd_digit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         value_i,
  input  logic                out_free_i,
  output logic                idle_o,
  output logic                res_valid_o,
  output udhcd_pkg::result_t  res_o
);

  udhcd_pkg::dig_state_e state_q, state_d;

  logic [31:0]                     rest_q, rest_d;
  logic [31:0]                     chk_q, chk_d;
  logic [3:0]                      mod_q, mod_d;
  logic                            odd_q, odd_d;
  logic                            first_q, first_d;
  logic                            div_en;
  logic [udhcd_pkg::QuotWidth-1:0] quot;
  logic [3:0]                      rem;
  logic [3:0]                      dig_w;
  logic [4:0]                      mod_sum;
  logic [3:0]                      raw;
  logic [4:0]                      raw_adj;
  logic [3:0]                      digit;

  udhcd_div10 u_div10 (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .value_i(rest_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  always_comb begin
    if (odd_q && !first_q) begin
      dig_w = (rem < 4'd5) ? 4'(rem << 1) : 4'((rem << 1) - 4'd9);
    end else begin
      dig_w = rem;
    end
    mod_sum = first_q ? {1'b0, rem} : {1'b0, mod_q} + {1'b0, dig_w};
    if (mod_sum >= 5'd10) begin
      mod_sum = mod_sum - 5'd10;
    end
  end

  always_comb begin
    raw     = (mod_q == 4'd0) ? 4'd0 : 4'd10 - mod_q;
    raw_adj = raw[0] ? {1'b0, raw} + 5'd9 : {1'b0, raw};
    digit   = (odd_q && raw != 4'd0) ? raw_adj[4:1] : raw;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      udhcd_pkg::DigIdle: if (start_i) state_d = udhcd_pkg::DigMul;
      udhcd_pkg::DigMul:  state_d = udhcd_pkg::DigAcc;
      udhcd_pkg::DigAcc: begin
        state_d = (quot == '0) ? udhcd_pkg::DigDone : udhcd_pkg::DigMul;
      end
      udhcd_pkg::DigDone: if (out_free_i) state_d = udhcd_pkg::DigIdle;
      default:            state_d = udhcd_pkg::DigIdle;
    endcase
  end

  always_comb begin
    rest_d      = rest_q;
    chk_d       = chk_q;
    mod_d       = mod_q;
    odd_d       = odd_q;
    first_d     = first_q;
    div_en      = 1'b0;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      udhcd_pkg::DigIdle: begin
        idle_o = 1'b1;
        if (start_i) begin
          rest_d  = value_i;
          chk_d   = value_i;
          mod_d   = '0;
          odd_d   = 1'b1;
          first_d = 1'b1;
        end
      end
      udhcd_pkg::DigMul: div_en = 1'b1;
      udhcd_pkg::DigAcc: begin
        rest_d  = {(32 - udhcd_pkg::QuotWidth)'(0), quot};
        mod_d   = mod_sum[3:0];
        first_d = 1'b0;
        if (!first_q) begin
          odd_d = ~odd_q;
        end
      end
      udhcd_pkg::DigDone: res_valid_o = out_free_i;
      default: ;
    endcase
  end

  assign res_o.checksum = chk_q;
  assign res_o.digit    = digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= udhcd_pkg::DigIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q  <= rest_d;
    chk_q   <= chk_d;
    mod_q   <= mod_d;
    odd_q   <= odd_d;
    first_q <= first_d;
  end

endmodule

@@ hdl/url_dual_hash_check_digit.sv @@
// Top level: byte stream in, checksum and check digit out.
// Bytes that do not end a string are taken one per cycle while the digit sequencer is idle.
// A last transfer starts the digit sequencer: it passes through its multiply and accumulate states for each
// decimal digit of the checksum (1 to 10 digits), then waits in its done state until the output register is free.
// Input ready stays low until the result has moved into the output register.
// Reset clears the hashes to their seeds and empties the output register.
module url_dual_hash_check_digit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tuser_i,   // [0] no_char
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] checksum_value, [35:32] check_digit
);

  logic               accept;
  logic               idle;
  logic [31:0]        sum;
  logic               out_free;
  logic               res_valid;
  udhcd_pkg::result_t res;
  logic               m_valid_q, m_valid_d;
  logic [39:0]        m_data_q, m_data_d;

  assign s_axis_tready_o = idle;
  assign accept          = s_axis_tvalid_i & idle;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  udhcd_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_byte_i(s_axis_tdata_i),
    .no_char_i  (s_axis_tuser_i),
    .last_i     (s_axis_tlast_i),
    .sum_o      (sum)
  );

  udhcd_digit u_digit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept & s_axis_tlast_i),
    .value_i    (sum),
    .out_free_i (out_free),
    .idle_o     (idle),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid) begin
      m_valid_d = 1'b1;
      m_data_d  = {4'b0, res.digit, res.checksum};
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

@@ test/url_dual_hash_check_digit_tb.sv @@
// Testbench for url_dual_hash_check_digit: byte strings in, predicted checksum and digit checked.
`timescale 1ns / 100ps

module url_dual_hash_check_digit_tb;

  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 40;
  localparam int RandomItems   = 800;

  typedef struct packed {
    logic [31:0] sum;
    logic [3:0]  digit;
  } sum_digit_t;

  logic        clk_i          = 1'b0;
  logic        rst_n          = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = 8'h00;
  logic        s_axis_tuser   = 1'b0;
  logic        s_axis_tlast   = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [39:0] m_axis_tdata;

  // predictor state
  logic [31:0] hash33_q    = udhcd_pkg::Times33Seed;
  logic [31:0] hash65599_q = 32'd0;
  bit          byte_taken  = 1'b0;
  sum_digit_t  pending_sums[$];

  int errors       = 0;
  int quiet_cycles = 0;
  int burst_left   = 0;
  int hold_tick    = 0;
  bit tx_gaps      = 1'b0;
  bit rx_stalls    = 1'b0;

  url_dual_hash_check_digit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),   // [7:0] char_byte
    .s_axis_tuser_i (s_axis_tuser),   // [0] no_char
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)    // [31:0] checksum_value, [35:32] check_digit
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bit shuffle of the x33 hash, merged with the even nibbles of the x65599 hash
  function automatic logic [31:0] shuffle_hashes(input logic [31:0] h33, input logic [31:0] h65599);
    logic [31:0] x;
    logic [31:0] mid;
    logic [31:0] rest;
    x    = ((h33 >> 6) & 32'h03ff_ffc0) | ((h33 >> 2) & 32'h0000_003f);
    x    = ((x >> 4) & 32'h003f_fc00) | (x & 32'h0000_03ff);
    x    = ((x >> 4) & 32'h0003_c000) | (x & 32'h0000_3fff);
    mid  = (((x & 32'h0000_03c0) << 4) | (x & 32'h0000_003c)) << 2;
    rest = ((x & 32'hffff_c000) << 4) | (x & 32'h0000_3c00);
    return (rest << 10) | mid | (h65599 & 32'h0f0f_0f0f);
  endfunction

  function automatic logic [3:0] luhn_digit(input logic [31:0] value);
    int unsigned total;
    int unsigned remaining;
    int unsigned d;
    int unsigned r;
    bit          doubling;
    total     = value % 10;
    remaining = value / 10;
    doubling  = 1'b1;
    while (remaining != 0) begin
      d = remaining % 10;
      if (doubling) d = d / 5 + (d * 2) % 10;
      total     += d;
      remaining /= 10;
      doubling  = !doubling;
    end
    r = (10 - total % 10) % 10;
    if (r == 0) return 4'd0;
    // odd digit count: halve the raw value
    if (doubling) return 4'((r[0] ? r + 9 : r) / 2);
    return 4'(r);
  endfunction

  function automatic void predict_checksum(input logic [7:0] ch, input bit skip, input bit ends);
    sum_digit_t want;
    logic [31:0] sext;
    sext = {{24{ch[7]}}, ch};
    if (!skip) begin
      hash33_q    = hash33_q * 32'd33 + sext;
      hash65599_q = hash65599_q * 32'd65599 + sext;
      byte_taken  = 1'b1;
    end
    if (ends) begin
      want.sum   = byte_taken ? shuffle_hashes(hash33_q, hash65599_q) : udhcd_pkg::EmptySum;
      want.digit = luhn_digit(want.sum);
      pending_sums.push_back(want);
      hash33_q    = udhcd_pkg::Times33Seed;
      hash65599_q = 32'd0;
      byte_taken  = 1'b0;
    end
  endfunction

  task automatic send_item(input logic [7:0] ch, input bit skip, input bit ends);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= skip;
    s_axis_tlast  <= ends;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_checksum(ch, skip, ends);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : receiver
    int hold_done;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_tick != hold_done) begin
        hold_done = hold_tick;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    sum_digit_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata[31:0] !== want.sum) begin
          $display("%0t: checksum: expected %h, got %h", $time, want.sum, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[35:32] !== want.digit) begin
          $display("%0t: check digit: expected %0d, got %0d", $time, want.digit,
                   m_axis_tdata[35:32]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_strings();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hA5, 1'b1, 1'b1);
  endtask

  task automatic test_byte_extremes();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h7F, 1'b0, 1'b1);
    send_item(8'h80, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    // zero byte inside a string does not end it
    send_item(8'h41, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h42, 1'b0, 1'b1);
  endtask

  task automatic test_skipped_bytes();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b0;
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);
  endtask

  task automatic test_output_backpressure();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_tick++;
    repeat (12) begin
      send_item(pick_byte(), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b0, 1'b1);
    end
  endtask

  task automatic test_random_strings();
    int sent;
    int len;
    int kind;
    bit tail_skip;
    sent = 0;
    while (sent < RandomItems) begin
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      kind      = $urandom_range(0, 19);
      if (kind == 0) begin
        send_item(pick_byte(), 1'b1, 1'b1);
        sent++;
      end else if (kind == 1) begin
        repeat ($urandom_range(1, 3)) send_item(pick_byte(), 1'b1, 1'b0);
      end else begin
        len       = (kind == 2) ? $urandom_range(20, 48) : $urandom_range(1, 10);
        tail_skip = $urandom_range(0, 4) == 0;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) send_item(pick_byte(), 1'b1, 1'b0);
          send_item(pick_byte(), 1'b0, (i == len - 1) && !tail_skip);
        end
        sent += len;
        if (tail_skip) begin
          send_item(pick_byte(), 1'b1, 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_empty_strings();
    test_byte_extremes();
    test_skipped_bytes();
    test_output_backpressure();
    test_random_strings();
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/udhcd_pkg.sv
hdl/udhcd_hash.sv
hdl/udhcd_div10.sv
hdl/udhcd_digit.sv
hdl/url_dual_hash_check_digit.sv
test/url_dual_hash_check_digit_tb.sv
